>>> sv/xor_float_word_encoder_macros.svh
// assertion macros for the xor float word encoder
// used by xor_float_word_encoder.sv, needs a clock and reset in scope
`ifndef XOR_FLOAT_WORD_ENCODER_MACROS_SVH
`define XOR_FLOAT_WORD_ENCODER_MACROS_SVH

// same-cycle implication
`define XFWE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XFWE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/xfwe_pkg.sv
// shared constants for the xor float word encoder
// no dependencies
package xfwe_pkg;

   localparam int WORD_BITS_DEFAULT = 64;

   localparam int DATA_W   = 64;
   localparam int CNT_W    = 7;
   localparam int HDR_W    = 11;
   localparam int HLEN_W   = 4;
   localparam int LZ_W     = 5;
   localparam int LZCODE_W = 3;
   localparam int CTRL_W   = 2;

   localparam logic [CTRL_W-1:0] CTRL_REUSE = 2'b00;
   localparam logic [CTRL_W-1:0] CTRL_ZERO  = 2'b01;
   localparam logic [CTRL_W-1:0] CTRL_SHORT = 2'b10;
   localparam logic [CTRL_W-1:0] CTRL_LONG  = 2'b11;

   localparam logic [HLEN_W-1:0] HLEN_FIRST = 4'd7;
   localparam logic [HLEN_W-1:0] HLEN_CTRL  = 4'd2;
   localparam logic [HLEN_W-1:0] HLEN_SHORT = 4'd9;
   localparam logic [HLEN_W-1:0] HLEN_LONG  = 4'd11;

   localparam logic [CNT_W-1:0] SHORT_MAX = 7'd16;
   localparam logic [3:0]       SHORT_MASK = 4'hf;
   localparam logic [5:0]       LONG_MASK  = 6'h3f;

   localparam logic [LZ_W-1:0] LZ_STEPS [8] = '{
      5'd0, 5'd8, 5'd12, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24
   };

endpackage

>>> sv/xor_float_word_encoder.sv
// xor float word encoder top level: input register, codeword logic, result register
// depends on xfwe_pkg and xor_float_word_encoder_macros.svh
//
// One word in, one codeword out, one word per cycle sustained while the
// output is taken: an item is held in the input register, its codeword is
// formed in a single pass (trailing-zero encode, quantised leading-zero
// compare, one barrel shift) and is held in the result register until
// taken. rsp_tvalid comes from the result register, which is loaded from
// the input register when it is free. The block state (previous word and
// window) is updated as each codeword is registered, so consecutive words
// chain without bubbles. A word sent with req_tlast high ends the block and
// the next word is coded as the first of a new block.
`include "xor_float_word_encoder_macros.svh"

module xor_float_word_encoder #(
   parameter int WORD_BITS = xfwe_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // word_value
   input  logic        req_tlast,   // last_of_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // header_code[10:0], header_length[14:11], payload_bits[78:15],
   // payload_length[85:79], zero[87:86]
   output logic [87:0] rsp_tdata,
   output logic        rsp_tlast    // block_end
);
   import xfwe_pkg::*;

   localparam logic [CNT_W-1:0] WB = CNT_W'(WORD_BITS);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [WORD_BITS-1:0] in_word_ff;
   logic                 in_last_ff;

   // block state
   logic                 first_pending_ff, first_pending_in;
   logic                 window_valid_ff, window_valid_in;
   logic [LZ_W-1:0]      prev_lead_ff, prev_lead_in;
   logic [CNT_W-1:0]     prev_trail_ff, prev_trail_in;
   logic [WORD_BITS-1:0] prev_word_ff, prev_word_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [HDR_W-1:0]     hcode_ff, hcode_in;
   logic [HLEN_W-1:0]    hlen_ff, hlen_in;
   logic [DATA_W-1:0]    pbits_ff, pbits_in;
   logic [CNT_W-1:0]     plen_ff, plen_in;
   logic                 last_ff;

   logic                 advance;
   logic                 out_free;

   logic [WORD_BITS-1:0] xor_word;
   logic [WORD_BITS-1:0] operand;
   logic [WORD_BITS-1:0] low_bit;
   logic                 is_zero;
   logic [CNT_W-1:0]     tz_enc;
   logic [CNT_W-1:0]     tz;
   logic [LZCODE_W-1:0]  lz_code;
   logic [LZ_W-1:0]      lz;
   logic                 reuse;
   logic [CNT_W-1:0]     shift_amt;
   logic [CNT_W-1:0]     center;
   logic [WORD_BITS-1:0] shifted;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // codeword logic
   always_comb begin
      xor_word = in_word_ff ^ prev_word_ff;
      operand  = first_pending_ff ? in_word_ff : xor_word;
      is_zero  = (operand == '0);
      low_bit  = operand & (~operand + WORD_BITS'(1));
      tz_enc   = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_bit[b]) begin
            tz_enc = tz_enc | CNT_W'(b);
         end
      end
      tz = is_zero ? WB : tz_enc;

      // quantised leading zeros: step k holds when the top LZ_STEPS[k] bits are clear
      lz_code = '0;
      for (int k = 1; k < 8; k++) begin
         if ((xor_word >> (WORD_BITS - int'(LZ_STEPS[k]))) == '0) begin
            lz_code = LZCODE_W'(k);
         end
      end
      lz = LZ_STEPS[lz_code];

      reuse = window_valid_ff && (lz == prev_lead_ff) && (tz >= prev_trail_ff);
      shift_amt = reuse ? prev_trail_ff : tz;
      center    = WB - CNT_W'(lz) - shift_amt;
      shifted   = operand >> shift_amt;

      first_pending_in = first_pending_ff;
      window_valid_in  = window_valid_ff;
      prev_lead_in     = prev_lead_ff;
      prev_trail_in    = prev_trail_ff;
      prev_word_in     = prev_word_ff;

      if (first_pending_ff) begin
         hcode_in         = HDR_W'(tz);
         hlen_in          = HLEN_FIRST;
         pbits_in         = DATA_W'(shifted);
         plen_in          = WB - tz;
         prev_trail_in    = tz;
         first_pending_in = 1'b0;
      end else if (is_zero) begin
         hcode_in = HDR_W'(CTRL_ZERO);
         hlen_in  = HLEN_CTRL;
         pbits_in = '0;
         plen_in  = '0;
      end else begin
         if (reuse) begin
            hcode_in = HDR_W'(CTRL_REUSE);
            hlen_in  = HLEN_CTRL;
         end else if (center <= SHORT_MAX) begin
            hcode_in = HDR_W'({CTRL_SHORT, lz_code, center[3:0] & SHORT_MASK});
            hlen_in  = HLEN_SHORT;
         end else begin
            hcode_in = {CTRL_LONG, lz_code, center[5:0] & LONG_MASK};
            hlen_in  = HLEN_LONG;
         end
         pbits_in        = DATA_W'(shifted);
         plen_in         = center;
         window_valid_in = 1'b1;
         prev_lead_in    = lz;
         prev_trail_in   = tz;
      end
      prev_word_in = in_word_ff;

      if (in_last_ff) begin
         first_pending_in = 1'b1;
         window_valid_in  = 1'b0;
         prev_lead_in     = '0;
         prev_trail_in    = '0;
         prev_word_in     = '0;
      end
   end

   assign in_valid_in  = req_tvalid && req_tready ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         first_pending_ff <= 1'b1;
         window_valid_ff  <= 1'b0;
         prev_lead_ff     <= '0;
         prev_trail_ff    <= '0;
         prev_word_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            first_pending_ff <= first_pending_in;
            window_valid_ff  <= window_valid_in;
            prev_lead_ff     <= prev_lead_in;
            prev_trail_ff    <= prev_trail_in;
            prev_word_ff     <= prev_word_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata[WORD_BITS-1:0];
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         hcode_ff <= hcode_in;
         hlen_ff  <= hlen_in;
         pbits_ff <= pbits_in;
         plen_ff  <= plen_in;
         last_ff  <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, plen_ff, pbits_ff, hlen_ff, hcode_ff};
   assign rsp_tlast  = last_ff;

   `XFWE_ASSERT_NOW(a_hlen_legal, rsp_tvalid,
      hlen_ff == HLEN_FIRST || hlen_ff == HLEN_CTRL || hlen_ff == HLEN_SHORT ||
      hlen_ff == HLEN_LONG, "header length outside the legal set")
   `XFWE_ASSERT_NOW(a_plen_range, rsp_tvalid, plen_ff <= WB,
      "payload length above word width")
   `XFWE_ASSERT_NOW(a_zero_empty, rsp_tvalid && hlen_ff == HLEN_CTRL &&
      hcode_ff == HDR_W'(CTRL_ZERO), plen_ff == '0, "zero xor word carries payload")
   `XFWE_ASSERT_NEXT(a_block_restart, advance && in_last_ff,
      first_pending_ff && !window_valid_ff, "block end did not restart state")

endmodule
